[hw/rtl/grs_pkg.sv]
// Package for the group reverse stream block.
// Holds the group store sizes, the sequencer state type and the
// control struct shared by the controller and the output stage.
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

    localparam int MAX_GROUP = 16;
    localparam int ADDR_W    = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int VALUE_W   = 32;
    localparam int GS_W      = 5;

    localparam logic [GS_W-1:0] GS_RESET = GS_W'(4);

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } state_t;

    // Read stage status handed from the controller to the output stage.
    typedef struct packed {
        logic valid;
        logic last;
    } rd_stage_t;

endpackage

`default_nettype wire

[hw/rtl/grs_ram.sv]
// Group store of the group reverse stream block.
// One write port and one read port with registered read data; uses grs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grs_ram
    import grs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [ADDR_W-1:0]         waddr,
    input  wire logic signed [VALUE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [ADDR_W-1:0]         raddr,
    output logic signed [VALUE_W-1:0]      rdata
);

    logic signed [VALUE_W-1:0] mem [MAX_GROUP];
    logic signed [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read data register holds while the read stage is stalled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/grs_ctrl.sv]
// Controller of the group reverse stream block: group size register,
// fill count, and the drain sequencer that reads the group store; uses grs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grs_ctrl
    import grs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [GS_W-1:0]   cfg_wdata,
    input  wire logic              in_valid,
    input  wire logic              seq_end,
    output logic                   in_stall,
    input  wire logic              take,
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output logic                   mem_re,
    output logic [ADDR_W-1:0]      mem_raddr,
    output rd_stage_t              rd_stage
);

    state_t              state_reg, state_next;
    logic [GS_W-1:0]     group_size_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                rev_reg, rev_next;
    logic                end_reg, end_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_last_reg, rd_last_next;

    logic                accept;
    logic                issue;
    logic [CNT_W-1:0]    eff_size;
    logic [CNT_W-1:0]    n_held;
    logic                full_group;

    always_comb
    begin
        if (32'(group_size_reg) > 32'(MAX_GROUP))
        begin
            eff_size = CNT_W'(MAX_GROUP);
        end
        else if (group_size_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else
        begin
            eff_size = CNT_W'(group_size_reg);
        end
    end

    // The fill count never reaches the store depth: a full store is always
    // at least one whole group.
    assign n_held     = fill_reg + CNT_W'(1);
    assign full_group = (n_held >= eff_size);
    assign accept     = in_valid && !in_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (accept && (full_group || seq_end))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (issue && left_reg == CNT_W'(1))
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // State outputs. Writes happen only while filling and reads only while
    // draining, so the two ports never touch the store in the same cycle.
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                in_stall = 1'b0;
            end
            ST_DRAIN:
            begin
                issue = !rd_valid_reg || take;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        fill_next     = fill_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        rev_next      = rev_reg;
        end_next      = end_reg;
        rd_valid_next = rd_valid_reg;
        rd_last_next  = rd_last_reg;

        if (accept)
        begin
            if (full_group)
            begin
                fill_next = '0;
                addr_next = fill_reg[ADDR_W-1:0];
                left_next = n_held;
                rev_next  = 1'b1;
                end_next  = seq_end;
            end
            else if (seq_end)
            begin
                fill_next = '0;
                addr_next = '0;
                left_next = n_held;
                rev_next  = 1'b0;
                end_next  = 1'b1;
            end
            else
            begin
                fill_next = n_held;
            end
        end

        if (issue)
        begin
            left_next     = left_reg - CNT_W'(1);
            addr_next     = rev_reg ? addr_reg - ADDR_W'(1) : addr_reg + ADDR_W'(1);
            rd_valid_next = 1'b1;
            rd_last_next  = (left_reg == CNT_W'(1)) && end_reg;
        end
        else if (take)
        begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            group_size_reg <= GS_RESET;
            fill_reg       <= '0;
            left_reg       <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            left_reg     <= left_next;
            rd_valid_reg <= rd_valid_next;
            if (cfg_we)
            begin
                group_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        rev_reg     <= rev_next;
        end_reg     <= end_next;
        rd_last_reg <= rd_last_next;
    end

    assign mem_we         = accept;
    assign mem_waddr      = fill_reg[ADDR_W-1:0];
    assign mem_re         = issue;
    assign mem_raddr      = addr_reg;
    assign rd_stage.valid = rd_valid_reg;
    assign rd_stage.last  = rd_last_reg;

endmodule

`default_nettype wire

[hw/rtl/grs_out.sv]
// Output register of the group reverse stream block.
// Takes a request from the read stage when it is free; uses grs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grs_out
    import grs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rd_stage_t                 rd_stage,
    input  wire logic signed [VALUE_W-1:0] rd_data,
    output logic                           take,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [VALUE_W-1:0]      out_value,
    output logic                           out_last
);

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      last_reg;
    logic                      free;

    assign free = !valid_reg || !out_stall;
    assign take = rd_stage.valid && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= rd_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= rd_data;
            last_reg  <= rd_stage.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

[hw/rtl/group_reverse_stream.sv]
// Top level of the group reverse stream block.
// Instantiates grs_ctrl, grs_ram and grs_out; uses grs_pkg.
//
// Usage: values enter on the input channel (in_valid, in_stall, value,
// seq_end) and leave on the output channel (out_valid, out_stall, out_value,
// out_last). Each value is written into the group store at the fill count.
// When a whole group of group_size values is held, the group is read back
// from the store newest first; when seq_end arrives with a partial group,
// the held values are read back oldest first. The final request of a
// sequence carries out_last. group_size is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle; the
// block itself does not enforce this. 0 acts as 1, and sizes above 16 act
// as 16. An input that closes a group of n values stalls the input side
// while the store is read, one entry per cycle through its single read
// port unless the read stage is full and stalled, and the results leave
// at one per cycle while the receiver does not stall. The first result of
// a group passes through the read register, then the output register.
// Reset clears the fill count, sets group_size to 4 and empties the output
// register; the store itself is not cleared. While the receiver stalls, the
// output register holds, the read stage holds once full, and reading pauses.
`timescale 1ns / 1ps
`default_nettype none

module group_reverse_stream
    import grs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [GS_W-1:0]           cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      seq_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [VALUE_W-1:0]      out_value,
    output logic                           out_last
);

    logic                      take;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_raddr;
    logic signed [VALUE_W-1:0] mem_rdata;
    rd_stage_t                 rd_stage;

    grs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .seq_end   (seq_end),
        .in_stall  (in_stall),
        .take      (take),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .rd_stage  (rd_stage)
    );

    grs_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    grs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_stage  (rd_stage),
        .rd_data   (mem_rdata),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

[hw/rtl/grs_checker.sv]
// Port-level checks for the group reverse stream block, bound to the top.
// Uses grs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module grs_checker
    import grs_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      seq_end,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [VALUE_W-1:0] out_value,
    input wire logic                      out_last
);

    // A stalled result request stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A stalled result request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_value) && $stable(out_last))
        else $error("output payload changed while stalled");

    // The end of a sequence always starts a drain of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && seq_end |=> in_stall)
        else $error("sequence end did not start a drain");

    // Right after reset the block is empty and ready for input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid && !in_stall)
        else $error("block not idle after reset");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .seq_end   (seq_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_last  (out_last)
);

`default_nettype wire
